[hdl/qecs_pkg.sv]
// ----------------------------------------------------------------------------
// qecs_pkg
// Shared types, Q.30 constants and fixed point helpers for the quasi-elastic
// cross section pipeline.
// ----------------------------------------------------------------------------
package qecs_pkg;

  // signed Q.30 working word
  typedef logic signed [63:0] q30_t;

  // partial products of a Q.30 multiply, summed one stage later
  typedef struct packed {
    logic        neg;
    logic [63:0] ll;
    logic [63:0] lh;
    logic [63:0] hl;
    logic [63:0] hh;
  } pp_t;

  localparam int FracBitsDefault = 20;

  localparam q30_t  ONE     = 64'sd1073741824;
  localparam q30_t  K_M     = 64'sd1008844868;
  localparam q30_t  K_MP    = 64'sd1007459741;
  localparam q30_t  K_MMU   = 64'sd113451561;
  localparam q30_t  K_MV    = 64'sd901943132;
  localparam q30_t  K_GM0   = 64'sd5053029024;
  localparam q30_t  K_FA0   = 64'sd1320702444;
  localparam q30_t  K_MPI   = 64'sd150323855;
  localparam logic [26:0] K_SCALE = 27'd131046532;
  localparam logic [25:0] OP_MAX  = 26'h3FFFFFF;

  // magnitudes split into 32 bit halves, four 32 by 32 products
  function automatic pp_t fmul_pp(input q30_t a, input q30_t b);
    logic [63:0] ma;
    logic [63:0] mb;
    pp_t         p;
    ma    = a[63] ? (~a + 64'd1) : a;
    mb    = b[63] ? (~b + 64'd1) : b;
    p.neg = a[63] ^ b[63];
    p.ll  = 64'(ma[31:0]) * 64'(mb[31:0]);
    p.lh  = 64'(ma[31:0]) * 64'(mb[63:32]);
    p.hl  = 64'(ma[63:32]) * 64'(mb[31:0]);
    p.hh  = 64'(ma[63:32]) * 64'(mb[63:32]);
    return p;
  endfunction

  // sum of partial products, round half away from zero and saturation
  function automatic q30_t fmul_sum(input pp_t p);
    logic [127:0] s;
    logic [62:0]  r;
    s = {64'd0, p.ll} + {32'd0, p.lh, 32'd0} + {32'd0, p.hl, 32'd0}
        + {p.hh, 64'd0} + (128'd1 << 29);
    if (|s[127:93]) r = {63{1'b1}};
    else            r = s[92:30];
    return p.neg ? -q30_t'({1'b0, r}) : q30_t'({1'b0, r});
  endfunction

  // product with round half away from zero and saturation
  function automatic q30_t fmul(input q30_t a, input q30_t b);
    return fmul_sum(fmul_pp(a, b));
  endfunction

  // dividend of the rounded reciprocal 2^60 / d
  function automatic logic [60:0] rcp_num(input logic [63:0] d);
    return (61'd1 << 60) + 61'(d >> 1);
  endfunction

  // reciprocal of a constant, evaluated at elaboration by long division
  function automatic q30_t frcp_c(input q30_t d);
    logic [60:0] n;
    logic [64:0] r;
    logic [60:0] q;
    if (d <= 0) return '0;
    n = rcp_num(d);
    r = '0;
    q = '0;
    for (int i = 60; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      q = {q[59:0], 1'b0};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[0] = 1'b1;
      end
    end
    return q30_t'({3'd0, q});
  endfunction

  // derived constants
  localparam q30_t MN2    = fmul(K_M, K_M);
  localparam q30_t MN4    = fmul(MN2, MN2);
  localparam q30_t MU2    = fmul(K_MMU, K_MMU);
  localparam q30_t MU4    = fmul(MU2, MU2);
  localparam q30_t MN2X2  = MN2 <<< 1;
  localparam q30_t MN2X4  = MN2 <<< 2;
  localparam q30_t I1     = frcp_c(MN2);
  localparam q30_t I2     = frcp_c(MN2 <<< 1);
  localparam q30_t I4     = frcp_c(MN2 <<< 2);
  localparam q30_t J4     = frcp_c(MN4 <<< 2);
  localparam q30_t J16    = frcp_c(MN4 <<< 4);
  localparam q30_t RMV2   = frcp_c(fmul(K_MV, K_MV));
  localparam q30_t MPI2   = fmul(K_MPI, K_MPI);
  localparam q30_t TWO_MP = K_MP <<< 1;

endpackage

[hdl/qecs_div.sv]
// ----------------------------------------------------------------------------
// qecs_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module qecs_div #(
  parameter int NW = 61,
  parameter int DW = 64,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem,
  output logic [SW-1:0] side_out
);

  logic [NW-1:0] num_s  [NW+1];
  logic [NW-1:0] quo_s  [NW+1];
  logic [DW-1:0] rem_s  [NW+1];
  logic [DW-1:0] den_s  [NW+1];
  logic [SW-1:0] side_s [NW+1];
  logic          vld_s  [NW+1];

  // stage zero is the input
  assign num_s[0]  = num;
  assign quo_s[0]  = '0;
  assign rem_s[0]  = '0;
  assign den_s[0]  = den;
  assign side_s[0] = side_in;
  assign vld_s[0]  = in_valid;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW:0] part;
    logic        take;

    // shift in the next dividend bit and try a subtract
    assign part = {rem_s[k], num_s[k][NW-1]};
    assign take = part >= {1'b0, den_s[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else if (en) begin
        vld_s[k+1] <= vld_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1]  <= take ? DW'(part - {1'b0, den_s[k]}) : part[DW-1:0];
        num_s[k+1]  <= num_s[k] << 1;
        quo_s[k+1]  <= {quo_s[k][NW-2:0], take};
        den_s[k+1]  <= den_s[k];
        side_s[k+1] <= side_s[k];
      end
    end
  end

  assign out_valid = vld_s[NW];
  assign quo       = quo_s[NW];
  assign rem       = rem_s[NW];
  assign side_out  = side_s[NW];

endmodule

[hdl/quasielastic_cross_section.sv]
// ----------------------------------------------------------------------------
// quasielastic_cross_section
// Quasi-elastic neutrino cross section with dipole form factors, pipelined.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while the result side does not
// stall, and returns one result per transaction, in order. The depth is set
// by the four parallel 61-stage reciprocal dividers for the form factors and
// the 100-stage divider by the squared neutrino energy; every Q.30 product
// takes two stages, 32 by 32 bit partial products first and then their sum
// with rounding and saturation. A stall on the result side holds the whole
// pipeline, and s_tready follows it in the same cycle.
module quasielastic_cross_section
  import qecs_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,  // neutrino_energy[23:0], second_operand[48:24], zero pad
  input  logic        s_tuser,  // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // cross_section[39:0]
  output logic [1:0]  m_tuser   // overflow[0], invalid[1]
);

  localparam int SH_R = (FRAC_BITS > 20) ? FRAC_BITS - 20 : 0;
  localparam int SH_L = (FRAC_BITS < 20) ? 20 - FRAC_BITS : 0;
  localparam logic [33:0] RND = (34'd1 << SH_R) >> 1;
  localparam logic [39:0] OUT_MAX = 40'h7F_FFFF_FFFF;
  localparam logic [39:0] OUT_MIN = 40'h80_0000_0000;
  localparam int SIDE_W = 1 + 64 + 64 + 26 + 1 + 1;

  // bring an operand to Q.20 with saturation
  function automatic logic [25:0] to_q20(input logic [24:0] raw);
    logic [33:0] w;
    w = ((34'(raw) + RND) >> SH_R) << SH_L;
    return (w > 34'(OP_MAX)) ? OP_MAX : w[25:0];
  endfunction

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // input conversion
  logic [25:0] e_in;
  logic [25:0] s2_in;
  logic        inv_in;
  always_comb begin
    e_in   = to_q20({1'b0, s_tdata[23:0]});
    s2_in  = to_q20(s_tdata[48:24]);
    inv_in = (e_in == '0) || (s_tuser && (s2_in > e_in));
  end

  // stage 0: converted operands
  logic        v0, act0, inv0;
  logic [25:0] e0, s20;
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      act0 <= s_tuser;
      inv0 <= inv_in;
      e0   <= e_in;
      s20  <= s2_in;
    end
  end

  // stage 1a: partial products of q squared
  logic        v1p, act1p, inv1p;
  logic [25:0] e1p, s21p;
  pp_t         pqq1p;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1p <= 1'b0;
    end else if (en) begin
      v1p <= v0;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      act1p <= act0;
      inv1p <= inv0;
      e1p   <= e0;
      s21p  <= s20;
      pqq1p <= fmul_pp(TWO_MP, q30_t'({28'd0, 26'(e0 - s20), 10'd0}));
    end
  end

  // stage 1b: q squared
  logic        v1, act1, inv1;
  logic [25:0] e1;
  q30_t        qq1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v1p;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      act1 <= act1p;
      inv1 <= inv1p;
      e1   <= e1p;
      qq1  <= act1p ? fmul_sum(pqq1p) : q30_t'({28'd0, s21p, 10'd0});
    end
  end

  // stage 2a: partial products of the dipole arguments
  logic        v2p, act2p, inv2p;
  logic [25:0] e2p;
  q30_t        qq2p;
  pp_t         pxv2p, ptau2p;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2p <= 1'b0;
    end else if (en) begin
      v2p <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      act2p  <= act1;
      inv2p  <= inv1;
      e2p    <= e1;
      qq2p   <= qq1;
      pxv2p  <= fmul_pp(qq1, RMV2);
      ptau2p <= fmul_pp(qq1, I4);
    end
  end

  // stage 2b: dipole arguments
  logic        v2, act2, inv2;
  logic [25:0] e2;
  q30_t        qq2, xvm2, tau2, xa2, pd2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v2p;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      act2 <= act2p;
      inv2 <= inv2p;
      e2   <= e2p;
      qq2  <= qq2p;
      xvm2 <= fmul_sum(pxv2p);
      tau2 <= fmul_sum(ptau2p);
      xa2  <= ONE + qq2p;
      pd2  <= MPI2 + qq2p;
    end
  end

  // stage 3a: partial products of the squared dipole terms
  logic        v3p, act3p, inv3p;
  logic [25:0] e3p;
  q30_t        qq3p, tau3p, td3p, pd3p;
  pp_t         pxsq3p, pxa3p;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3p <= 1'b0;
    end else if (en) begin
      v3p <= v2;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      act3p  <= act2;
      inv3p  <= inv2;
      e3p    <= e2;
      qq3p   <= qq2;
      tau3p  <= tau2;
      td3p   <= ONE + tau2;
      pd3p   <= pd2;
      pxsq3p <= fmul_pp(ONE + xvm2, ONE + xvm2);
      pxa3p  <= fmul_pp(xa2, xa2);
    end
  end

  // stage 3b: divisors of the four reciprocals
  logic        v3, act3, inv3;
  logic [25:0] e3;
  q30_t        qq3, tau3, xsq3, xasq3, td3, pd3;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v3p;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      act3  <= act3p;
      inv3  <= inv3p;
      e3    <= e3p;
      qq3   <= qq3p;
      tau3  <= tau3p;
      xsq3  <= fmul_sum(pxsq3p);
      xasq3 <= fmul_sum(pxa3p);
      td3   <= td3p;
      pd3   <= pd3p;
    end
  end

  // reciprocals: non-positive divisors give zero
  logic        zg, zt, za, zp;
  logic [63:0] dg, dt, da, dp;
  always_comb begin
    zg = (xsq3 <= 0);
    zt = (td3 <= 0);
    za = (xasq3 <= 0);
    zp = (pd3 <= 0);
    dg = zg ? 64'd1 : xsq3;
    dt = zt ? 64'd1 : td3;
    da = za ? 64'd1 : xasq3;
    dp = zp ? 64'd1 : pd3;
  end

  logic              vg, vt, va, vp;
  logic [60:0]       qg, qt, qa, qp;
  logic [SIDE_W-1:0] side_g;
  logic              zt_o, za_o, zp_o;

  qecs_div #(.NW(61), .DW(64), .SW(SIDE_W)) u_div_ge (
    .clk(clk), .rst(rst), .en(en), .in_valid(v3),
    .num(rcp_num(dg)), .den(dg),
    .side_in({zg, qq3, tau3, e3, act3, inv3}),
    .out_valid(vg), .quo(qg), .rem(), .side_out(side_g)
  );
  qecs_div #(.NW(61), .DW(64), .SW(1)) u_div_tau (
    .clk(clk), .rst(rst), .en(en), .in_valid(v3),
    .num(rcp_num(dt)), .den(dt), .side_in(zt),
    .out_valid(vt), .quo(qt), .rem(), .side_out(zt_o)
  );
  qecs_div #(.NW(61), .DW(64), .SW(1)) u_div_fa (
    .clk(clk), .rst(rst), .en(en), .in_valid(v3),
    .num(rcp_num(da)), .den(da), .side_in(za),
    .out_valid(va), .quo(qa), .rem(), .side_out(za_o)
  );
  qecs_div #(.NW(61), .DW(64), .SW(1)) u_div_fp (
    .clk(clk), .rst(rst), .en(en), .in_valid(v3),
    .num(rcp_num(dp)), .den(dp), .side_in(zp),
    .out_valid(vp), .quo(qp), .rem(), .side_out(zp_o)
  );

  // unpack divider results
  q30_t        ge_c, itau_c, ra_c, rp_c, qq_c, tau_c;
  logic [25:0] e_c;
  logic        act_c, inv_c, zg_o;
  always_comb begin
    {zg_o, qq_c, tau_c, e_c, act_c, inv_c} = side_g;
    ge_c   = zg_o ? '0 : q30_t'({3'd0, qg});
    itau_c = zt_o ? '0 : q30_t'({3'd0, qt});
    ra_c   = za_o ? '0 : q30_t'({3'd0, qa});
    rp_c   = zp_o ? '0 : q30_t'({3'd0, qp});
  end

  // stage 4a: partial products for the magnetic and axial factors
  logic        v4p, act4p, inv4p;
  logic [25:0] e4p;
  q30_t        ge4p, itau4p, rp4p, tau4p, qq4p;
  pp_t         pgm4p, pfa4p, psu4p, pqsq4p;
  always_ff @(posedge clk) begin
    if (rst) begin
      v4p <= 1'b0;
    end else if (en) begin
      v4p <= vg && vt && va && vp;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      act4p  <= act_c;
      inv4p  <= inv_c;
      e4p    <= e_c;
      ge4p   <= ge_c;
      itau4p <= itau_c;
      rp4p   <= rp_c;
      tau4p  <= tau_c;
      qq4p   <= qq_c;
      pgm4p  <= fmul_pp(K_GM0, ge_c);
      pfa4p  <= fmul_pp(K_FA0, ra_c);
      psu4p  <= fmul_pp(q30_t'({26'd0, e_c, 12'd0}), K_M);
      pqsq4p <= fmul_pp(qq_c, qq_c);
    end
  end

  // stage 4b: magnetic and axial factors, kinematic terms
  logic        v4, act4, inv4;
  logic [25:0] e4;
  q30_t        ge4, itau4, rp4, gm4, fa4, tau4, q4, su4, qsq4, dm4;
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v4p;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      act4  <= act4p;
      inv4  <= inv4p;
      e4    <= e4p;
      ge4   <= ge4p;
      itau4 <= itau4p;
      rp4   <= rp4p;
      gm4   <= fmul_sum(pgm4p);
      fa4   <= -fmul_sum(pfa4p);
      tau4  <= tau4p;
      q4    <= -qq4p;
      su4   <= fmul_sum(psu4p) - qq4p - MU2;
      qsq4  <= fmul_sum(pqsq4p);
      dm4   <= MU2 + qq4p;
    end
  end

  // stage 5a: partial products of the first level
  logic        v5p, act5p, inv5p;
  logic [25:0] e5p;
  q30_t        ge5p, f2in5p, itau5p, rp5p, fa5p, qsq5p, dm5p;
  pp_t         ptg5p, pfp5p, pmq5p, pmndm5p, pqsqdm5p, pmudm5p, pqsu5p, psusu5p;
  pp_t         pqi5p, pm4x5p;
  always_ff @(posedge clk) begin
    if (rst) begin
      v5p <= 1'b0;
    end else if (en) begin
      v5p <= v4;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      act5p    <= act4;
      inv5p    <= inv4;
      e5p      <= e4;
      ge5p     <= ge4;
      f2in5p   <= gm4 - ge4;
      itau5p   <= itau4;
      rp5p     <= rp4;
      fa5p     <= fa4;
      qsq5p    <= qsq4;
      dm5p     <= dm4;
      ptg5p    <= fmul_pp(tau4, gm4);
      pfp5p    <= fmul_pp(MN2X2, fa4);
      pmq5p    <= fmul_pp(MU2, q4);
      pmndm5p  <= fmul_pp(MN2X4, dm4);
      pqsqdm5p <= fmul_pp(qsq4, dm4);
      pmudm5p  <= fmul_pp(MU2, dm4);
      pqsu5p   <= fmul_pp(q4, su4);
      psusu5p  <= fmul_pp(su4, su4);
      pqi5p    <= fmul_pp(q4, I4);
      pm4x5p   <= fmul_pp(MN2X4, qsq4 - MU4);
    end
  end

  // stage 5b: first level products
  logic        v5, act5, inv5;
  logic [25:0] e5;
  q30_t        itau5, rp5, fa5, qsq5, dm5, f1in5, f2in5, fp15, mq5, mndm5;
  q30_t        qsqdm5, mudm5, qsu5, susu5, qi45, m4x5;
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v5p;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      act5   <= act5p;
      inv5   <= inv5p;
      e5     <= e5p;
      itau5  <= itau5p;
      rp5    <= rp5p;
      fa5    <= fa5p;
      qsq5   <= qsq5p;
      dm5    <= dm5p;
      f1in5  <= ge5p + fmul_sum(ptg5p);
      f2in5  <= f2in5p;
      fp15   <= fmul_sum(pfp5p);
      mq5    <= fmul_sum(pmq5p);
      mndm5  <= fmul_sum(pmndm5p);
      qsqdm5 <= fmul_sum(pqsqdm5p);
      mudm5  <= fmul_sum(pmudm5p);
      qsu5   <= fmul_sum(pqsu5p);
      susu5  <= fmul_sum(psusu5p);
      qi45   <= fmul_sum(pqi5p);
      m4x5   <= fmul_sum(pm4x5p);
    end
  end

  // stage 6a: partial products of the form factors and coefficients
  logic        v6p, act6p, inv6p;
  logic [25:0] e6p;
  q30_t        fa6p, c2in6p, qi46p;
  pp_t         pf1_6p, pf2_6p, pfp6p, pc1_6p, pmqdm6p, pc4_6p, pc5_6p, pc6_6p, pc7_6p;
  always_ff @(posedge clk) begin
    if (rst) begin
      v6p <= 1'b0;
    end else if (en) begin
      v6p <= v5;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      act6p   <= act5;
      inv6p   <= inv5;
      e6p     <= e5;
      fa6p    <= fa5;
      c2in6p  <= m4x5 - qsqdm5;
      qi46p   <= qi45;
      pf1_6p  <= fmul_pp(f1in5, itau5);
      pf2_6p  <= fmul_pp(f2in5, itau5);
      pfp6p   <= fmul_pp(fp15, rp5);
      pc1_6p  <= fmul_pp(qsq5 - mndm5 - MU4, I4);
      pmqdm6p <= fmul_pp(mq5, dm5);
      pc4_6p  <= fmul_pp((qsq5 <<< 1) + mq5 + MU4, I2);
      pc5_6p  <= fmul_pp(mudm5, I2);
      pc6_6p  <= fmul_pp(qsu5, I1);
      pc7_6p  <= fmul_pp(susu5, I4);
    end
  end

  // stage 6b: form factors and bracket coefficients
  logic        v6, act6, inv6;
  logic [25:0] e6;
  q30_t        f1_6, f2_6, fp6, fa6, c1_6, c2in6, mqdm6, c4_6, c5_6, c6_6, c7_6, qi46;
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v6p;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      act6  <= act6p;
      inv6  <= inv6p;
      e6    <= e6p;
      f1_6  <= fmul_sum(pf1_6p);
      f2_6  <= fmul_sum(pf2_6p);
      fp6   <= fmul_sum(pfp6p);
      fa6   <= fa6p;
      c1_6  <= fmul_sum(pc1_6p);
      c2in6 <= c2in6p;
      mqdm6 <= fmul_sum(pmqdm6p);
      c4_6  <= fmul_sum(pc4_6p);
      c5_6  <= fmul_sum(pc5_6p);
      c6_6  <= fmul_sum(pc6_6p);
      c7_6  <= fmul_sum(pc7_6p);
      qi46  <= qi46p;
    end
  end

  // stage 7a: partial products of the form factor squares
  logic        v7p, act7p, inv7p;
  logic [25:0] e7p;
  q30_t        c1_7p, c4_7p, c5_7p, c6_7p, c7_7p, qi47p;
  pp_t         pf1s7p, pf2s7p, pfas7p, pfpp7p, pf1f27p, pfafp7p, pfa127p, pc2_7p, pc3_7p;
  always_ff @(posedge clk) begin
    if (rst) begin
      v7p <= 1'b0;
    end else if (en) begin
      v7p <= v6;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      act7p   <= act6;
      inv7p   <= inv6;
      e7p     <= e6;
      c1_7p   <= c1_6;
      c4_7p   <= c4_6;
      c5_7p   <= c5_6;
      c6_7p   <= c6_6;
      c7_7p   <= c7_6;
      qi47p   <= qi46;
      pf1s7p  <= fmul_pp(f1_6, f1_6);
      pf2s7p  <= fmul_pp(f2_6, f2_6);
      pfas7p  <= fmul_pp(fa6, fa6);
      pfpp7p  <= fmul_pp(fp6, fp6);
      pf1f27p <= fmul_pp(f1_6, f2_6);
      pfafp7p <= fmul_pp(fa6, fp6);
      pfa127p <= fmul_pp(fa6, f1_6 + f2_6);
      pc2_7p  <= fmul_pp(c2in6, J16);
      pc3_7p  <= fmul_pp(mqdm6, J4);
    end
  end

  // stage 7b: squares and cross products of the form factors
  logic        v7, act7, inv7;
  logic [25:0] e7;
  q30_t        f1s7, f2s7, fas7, fpp7, f1f27, fafp7, fa127, c1_7, c2_7, c3_7;
  q30_t        c4_7, c5_7, c6_7, c7_7, qi47;
  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v7p;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      act7  <= act7p;
      inv7  <= inv7p;
      e7    <= e7p;
      f1s7  <= fmul_sum(pf1s7p);
      f2s7  <= fmul_sum(pf2s7p);
      fas7  <= fmul_sum(pfas7p);
      fpp7  <= fmul_sum(pfpp7p);
      f1f27 <= fmul_sum(pf1f27p);
      fafp7 <= fmul_sum(pfafp7p);
      fa127 <= fmul_sum(pfa127p);
      c1_7  <= c1_7p;
      c2_7  <= fmul_sum(pc2_7p);
      c3_7  <= fmul_sum(pc3_7p);
      c4_7  <= c4_7p;
      c5_7  <= c5_7p;
      c6_7  <= c6_7p;
      c7_7  <= c7_7p;
      qi47  <= qi47p;
    end
  end

  // stage 8a: partial products of the bracket terms
  logic        v8p, act8p, inv8p;
  logic [25:0] e8p;
  q30_t        f1s8p, fas8p, c7_8p;
  pp_t         pt1_8p, pt2_8p, pt3_8p, pt4_8p, pt5_8p, pt6_8p, pg7_8p;
  always_ff @(posedge clk) begin
    if (rst) begin
      v8p <= 1'b0;
    end else if (en) begin
      v8p <= v7;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      act8p  <= act7;
      inv8p  <= inv7;
      e8p    <= e7;
      f1s8p  <= f1s7;
      fas8p  <= fas7;
      c7_8p  <= c7_7;
      pt1_8p <= fmul_pp(f1s7 + fas7, c1_7);
      pt2_8p <= fmul_pp(f2s7, c2_7);
      pt3_8p <= fmul_pp(fpp7, c3_7);
      pt4_8p <= fmul_pp(f1f27, c4_7);
      pt5_8p <= fmul_pp(fafp7, c5_7);
      pt6_8p <= fmul_pp(fa127, c6_7);
      pg7_8p <= fmul_pp(f2s7, qi47);
    end
  end

  // stage 8b: bracket terms
  logic        v8, act8, inv8;
  logic [25:0] e8;
  q30_t        t1_8, t2_8, t3_8, t4_8, t5_8, t6_8, g7_8, f1s8, fas8, c7_8;
  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= v8p;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      act8 <= act8p;
      inv8 <= inv8p;
      e8   <= e8p;
      t1_8 <= fmul_sum(pt1_8p);
      t2_8 <= fmul_sum(pt2_8p);
      t3_8 <= fmul_sum(pt3_8p);
      t4_8 <= fmul_sum(pt4_8p);
      t5_8 <= fmul_sum(pt5_8p);
      t6_8 <= fmul_sum(pt6_8p);
      g7_8 <= fmul_sum(pg7_8p);
      f1s8 <= f1s8p;
      fas8 <= fas8p;
      c7_8 <= c7_8p;
    end
  end

  // stage 9a: partial sum and partial products of the last term
  logic        v9p, act9p, inv9p;
  logic [25:0] e9p;
  q30_t        sa9p;
  pp_t         pt7_9p;
  always_ff @(posedge clk) begin
    if (rst) begin
      v9p <= 1'b0;
    end else if (en) begin
      v9p <= v8;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      act9p  <= act8;
      inv9p  <= inv8;
      e9p    <= e8;
      sa9p   <= t1_8 + t2_8 - t3_8 + t4_8 - t5_8 + t6_8;
      pt7_9p <= fmul_pp(f1s8 - g7_8 + fas8, c7_8);
    end
  end

  // stage 9b: last term and partial sum
  logic        v9, act9, inv9;
  logic [25:0] e9;
  q30_t        t7_9, sa9;
  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (en) begin
      v9 <= v9p;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      act9 <= act9p;
      inv9 <= inv9p;
      e9   <= e9p;
      t7_9 <= fmul_sum(pt7_9p);
      sa9  <= sa9p;
    end
  end

  // stage 10: bracket total
  logic        v10, act10, inv10;
  logic [25:0] e10;
  q30_t        a10;
  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else if (en) begin
      v10 <= v9;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      act10 <= act9;
      inv10 <= inv9;
      e10   <= e9;
      a10   <= sa9 + t7_9;
    end
  end

  // stage 11a: partial products of the jacobian
  logic        v11p, act11p, inv11p;
  logic [25:0] e11p;
  q30_t        a11p;
  pp_t         pa11p;
  always_ff @(posedge clk) begin
    if (rst) begin
      v11p <= 1'b0;
    end else if (en) begin
      v11p <= v10;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      act11p <= act10;
      inv11p <= inv10;
      e11p   <= e10;
      a11p   <= a10;
      pa11p  <= fmul_pp(a10, TWO_MP);
    end
  end

  // stage 11b: jacobian for muon energy operand
  logic        v11, inv11;
  logic [25:0] e11;
  q30_t        a11;
  always_ff @(posedge clk) begin
    if (rst) begin
      v11 <= 1'b0;
    end else if (en) begin
      v11 <= v11p;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      inv11 <= inv11p;
      e11   <= e11p;
      a11   <= act11p ? fmul_sum(pa11p) : a11p;
    end
  end

  // stage 12: magnitude and sign
  logic        v12, inv12, neg12;
  logic [25:0] e12;
  logic [63:0] mag12;
  always_ff @(posedge clk) begin
    if (rst) begin
      v12 <= 1'b0;
    end else if (en) begin
      v12 <= v11;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      inv12 <= inv11;
      e12   <= e11;
      neg12 <= a11[63];
      mag12 <= a11[63] ? (~a11 + 64'd1) : a11;
    end
  end

  // stage 13a: halves of the scaled dividend and squared energy
  logic        v13p, inv13p, neg13p;
  logic [58:0] plo13p, phi13p;
  logic [51:0] d13p;
  always_ff @(posedge clk) begin
    if (rst) begin
      v13p <= 1'b0;
    end else if (en) begin
      v13p <= v12;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      inv13p <= inv12;
      neg13p <= neg12;
      plo13p <= 59'(mag12[31:0]) * 59'(K_SCALE);
      phi13p <= 59'(mag12[63:32]) * 59'(K_SCALE);
      d13p   <= 52'(e12) * 52'(e12);
    end
  end

  // stage 13b: scaled dividend
  logic        v13, inv13, neg13;
  logic [89:0] prod13;
  logic [51:0] d13;
  always_ff @(posedge clk) begin
    if (rst) begin
      v13 <= 1'b0;
    end else if (en) begin
      v13 <= v13p;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      inv13  <= inv13p;
      neg13  <= neg13p;
      prod13 <= 90'({phi13p, 32'd0}) + 90'(plo13p);
      d13    <= d13p;
    end
  end

  // division by the squared energy
  logic        vd;
  logic [99:0] qd;
  logic [51:0] rd, dd;
  logic        negd, invd;
  qecs_div #(.NW(100), .DW(52), .SW(54)) u_div_out (
    .clk(clk), .rst(rst), .en(en), .in_valid(v13),
    .num({prod13, 10'd0}), .den(inv13 ? 52'd1 : d13),
    .side_in({neg13, inv13, d13}),
    .out_valid(vd), .quo(qd), .rem(rd), .side_out({negd, invd, dd})
  );

  // rounding, saturation and invalid handling
  logic [50:0] qr;
  logic [50:0] lim;
  logic        big, ovf;
  logic [39:0] mag_o, val_o;
  always_comb begin
    big   = |qd[99:50];
    qr    = qd[50:0] + 51'({rd, 1'b0} >= {1'b0, dd});
    lim   = negd ? 51'(OUT_MIN) : 51'(OUT_MAX);
    ovf   = big || (qr > lim);
    mag_o = ovf ? lim[39:0] : qr[39:0];
    val_o = negd ? (~mag_o + 40'd1) : mag_o;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vd;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= invd ? 40'd0 : val_o;
      m_tuser <= invd ? 2'b10 : {1'b0, ovf};
    end
  end

endmodule

[tb/sv/quasielastic_cross_section_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quasielastic_cross_section_tb
// Drives neutrino energy / operand transactions through the cross section
// pipeline and checks every result against a bit-exact fixed point predictor or typed-in value.
// ----------------------------------------------------------------------------
module quasielastic_cross_section_tb;
  import qecs_pkg::q30_t;

  localparam int FRAC = 20;
  localparam int NUM_RANDOM = 1400;
  localparam logic ACT_Q2 = 1'b0;
  localparam logic ACT_EMU = 1'b1;
  localparam q30_t C_ONE = 64'sd1073741824;
  localparam q30_t C_M = 64'sd1008844868;
  localparam q30_t C_MP = 64'sd1007459741;
  localparam q30_t C_MMU = 64'sd113451561;
  localparam q30_t C_MV = 64'sd901943132;
  localparam q30_t C_GM0 = 64'sd5053029024;
  localparam q30_t C_FA0 = 64'sd1320702444;
  localparam q30_t C_MPI = 64'sd150323855;
  localparam logic [63:0] C_SCALE = 64'd131046532;
  localparam logic [63:0] C_OPMAX = 64'h3FFFFFF;
  localparam logic [63:0] C_LIM = 64'd1 << 39;

  typedef struct packed {
    logic [39:0] xsec;
    logic        ovf;
    logic        inval;
  } xsec_t;

  typedef struct {
    logic        act;
    logic [23:0] enu;
    logic [24:0] op;
    logic        known;
    xsec_t       res;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;

  xsec_t expected_xsec[$];
  stim_row_t directed[$];
  int  errors = 0;
  bit  stim_done = 0;
  bit  hold_rx = 0;

  quasielastic_cross_section DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [63:0] magn(input q30_t v);
    return v < 0 ? -v : v;
  endfunction

  function automatic q30_t qmul(input q30_t a, input q30_t b);
    logic [127:0] p;
    logic [63:0]  r;
    p = 128'(magn(a)) * 128'(magn(b)) + (128'd1 << 29);
    if (|p[127:93]) r = 64'h7FFF_FFFF_FFFF_FFFF;
    else r = {1'b0, p[92:30]};
    return ((a < 0) != (b < 0)) ? -q30_t'(r) : q30_t'(r);
  endfunction

  function automatic q30_t qrcp(input q30_t d);
    if (d <= 0) return 0;
    return q30_t'(((64'd1 << 60) + (64'(d) >> 1)) / 64'(d));
  endfunction

  function automatic logic [63:0] sat_q20(input logic [63:0] raw);
    return raw > C_OPMAX ? C_OPMAX : raw;
  endfunction

  function automatic q30_t llewellyn_bracket(input q30_t en, input q30_t qq);
    q30_t q, mn2, mn4, mu2, mu4, i1, i2, i4, j4, j16, xv, ge, gm, tau, itau;
    q30_t f1, f2, xa, fa, fp, su, qsq, dm, f1s, f2s, fas, acc;
    q = -qq;
    mn2 = qmul(C_M, C_M); mn4 = qmul(mn2, mn2);
    mu2 = qmul(C_MMU, C_MMU); mu4 = qmul(mu2, mu2);
    i1 = qrcp(mn2); i2 = qrcp(2 * mn2); i4 = qrcp(4 * mn2);
    j4 = qrcp(4 * mn4); j16 = qrcp(16 * mn4);
    xv = C_ONE + qmul(qq, qrcp(qmul(C_MV, C_MV)));
    ge = qrcp(qmul(xv, xv));
    gm = qmul(C_GM0, ge);
    tau = qmul(qq, i4);
    itau = qrcp(C_ONE + tau);
    f1 = qmul(ge + qmul(tau, gm), itau);
    f2 = qmul(gm - ge, itau);
    xa = C_ONE + qq;
    fa = -qmul(C_FA0, qrcp(qmul(xa, xa)));
    fp = qmul(qmul(2 * mn2, fa), qrcp(qmul(C_MPI, C_MPI) + qq));
    su = qmul(4 * en, C_M) + q - mu2;
    qsq = qmul(q, q); dm = mu2 - q;
    f1s = qmul(f1, f1); f2s = qmul(f2, f2); fas = qmul(fa, fa);
    acc = qmul(f1s + fas, qmul(qsq - qmul(4 * mn2, dm) - mu4, i4));
    acc += qmul(f2s, qmul(qmul(4 * mn2, qsq - mu4) - qmul(qsq, dm), j16));
    acc -= qmul(qmul(fp, fp), qmul(qmul(qmul(mu2, q), dm), j4));
    acc += qmul(qmul(f1, f2), qmul(2 * qsq + qmul(q, mu2) + mu4, i2));
    acc -= qmul(qmul(fa, fp), qmul(qmul(mu2, dm), i2));
    acc += qmul(qmul(fa, f1 + f2), qmul(qmul(q, su), i1));
    acc += qmul(f1s - qmul(f2s, qmul(q, i4)) + fas, qmul(qmul(su, su), i4));
    return acc;
  endfunction

  function automatic xsec_t predict_xsec(input logic act, input logic [23:0] enu,
                                         input logic [24:0] op);
    logic [63:0]  e, s2, d, q, lim;
    logic [127:0] num, r;
    q30_t         qq, a;
    xsec_t        res;
    logic         big;
    e = sat_q20(64'(enu));
    s2 = sat_q20(64'(op));
    res = '0;
    if (e == 0 || (act && s2 > e)) begin
      res.inval = 1'b1;
      return res;
    end
    if (act) qq = qmul(2 * C_MP, q30_t'((e - s2) << 10));
    else qq = q30_t'(s2 << 10);
    a = llewellyn_bracket(q30_t'(e << 10), qq);
    if (act) a = qmul(a, 2 * C_MP);
    num = (128'(magn(a)) * 128'(C_SCALE)) << 10;
    d = e * e;
    q = 0;
    r = 0;
    big = 0;
    for (int i = 127; i >= 0; i--) begin
      r = (r << 1) | 128'(num[i]);
      if (r >= 128'(d)) begin
        r = r - 128'(d);
        if (!big) q = (q << 1) | 64'd1;
      end else if (!big) begin
        q = q << 1;
      end
      if (!big && (q >> 50) != 0) big = 1;
    end
    if (!big && 2 * r >= 128'(d)) q++;
    lim = (a < 0) ? C_LIM : C_LIM - 1;
    if (big || q > lim) begin
      q = lim;
      res.ovf = 1'b1;
    end
    res.xsec = (a < 0) ? 40'(-q) : 40'(q);
    return res;
  endfunction

  // ---------------------------------------------------------------- sender
  task automatic send_item(input logic act, input logic [23:0] enu,
                           input logic [24:0] op, input xsec_t exp_res);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {7'd0, op, enu};
    do @(posedge clk); while (!s_tready);
    expected_xsec.push_back(exp_res);
    @(negedge clk);
    if ($urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic add_row(input logic act, input logic [23:0] enu, input logic [24:0] op,
                         input logic known, input xsec_t res);
    stim_row_t row;
    row.act = act; row.enu = enu; row.op = op; row.known = known; row.res = res;
    directed.push_back(row);
  endtask

  initial begin
    logic        act;
    logic [23:0] enu;
    logic [24:0] op;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = 0;
    rst = 1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // invalid kinematics and extremes: known results typed in
    add_row(ACT_Q2, 24'd0, 25'd0, 1, '{40'd0, 1'b0, 1'b1});
    add_row(ACT_Q2, 24'd0, 25'h1FFFFFF, 1, '{40'd0, 1'b0, 1'b1});
    add_row(ACT_EMU, 24'd0, 25'd0, 1, '{40'd0, 1'b0, 1'b1});
    add_row(ACT_EMU, 24'd100, 25'd101, 1, '{40'd0, 1'b0, 1'b1});
    add_row(ACT_EMU, 24'hFFFFFF, 25'h1FFFFFF, 1, '{40'd0, 1'b0, 1'b1});
    add_row(ACT_EMU, 24'h100000, 25'h100001, 1, '{40'd0, 1'b0, 1'b1});
    // remaining rows are predicted
    add_row(ACT_Q2, 24'd1, 25'd0, 0, '0);
    add_row(ACT_Q2, 24'd1, 25'h1FFFFFF, 0, '0);
    add_row(ACT_Q2, 24'hFFFFFF, 25'd0, 0, '0);
    add_row(ACT_Q2, 24'hFFFFFF, 25'h1FFFFFF, 0, '0);
    add_row(ACT_Q2, 24'h100000, 25'h080000, 0, '0);
    add_row(ACT_Q2, 24'h200000, 25'h100000, 0, '0);
    add_row(ACT_Q2, 24'h040000, 25'h1000000, 0, '0);
    add_row(ACT_EMU, 24'h100000, 25'h100000, 0, '0);
    add_row(ACT_EMU, 24'h100000, 25'd0, 0, '0);
    add_row(ACT_EMU, 24'hFFFFFF, 25'd0, 0, '0);
    add_row(ACT_EMU, 24'hFFFFFF, 25'hFFFFFF, 0, '0);
    add_row(ACT_EMU, 24'd1, 25'd1, 0, '0);
    add_row(ACT_EMU, 24'h300000, 25'h2A0000, 0, '0);
    add_row(ACT_Q2, 24'h555555, 25'h0AAAAAA, 0, '0);
    add_row(ACT_Q2, 24'hAAAAAA, 25'h1555555, 0, '0);

    foreach (directed[i])
      send_item(directed[i].act, directed[i].enu, directed[i].op,
                directed[i].known ? directed[i].res
                : predict_xsec(directed[i].act, directed[i].enu, directed[i].op));

    // random part: mostly physical kinematics, some raw full-range noise
    for (int n = 0; n < NUM_RANDOM; n++) begin
      act = $urandom_range(0, 1);
      case ($urandom_range(0, 9))
        0, 1: begin
          enu = $urandom;
          op = $urandom;
        end
        2: begin
          enu = $urandom_range(1, 255);
          op = $urandom_range(0, 255);
        end
        default: begin
          enu = $urandom_range(24'h020000, 24'hA00000);
          if (act) op = $urandom_range(0, enu);
          else op = $urandom_range(0, 25'h400000);
        end
      endcase
      send_item(act, enu, op, predict_xsec(act, enu, op));
    end
    s_tvalid <= 1'b0;
    stim_done = 1;
  end

  // ---------------------------------------------------------------- receiver
  initial begin
    m_tready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_rx) m_tready <= 1'b0;
      else if ($urandom_range(0, 4) == 0)
        m_tready <= 1'b0;
      else m_tready <= 1'b1;
      @(negedge clk);
    end
  end

  // long hold-off so the pipeline fills and s_tready drops
  initial begin
    wait (!rst);
    repeat (300) @(posedge clk);
    hold_rx = 1;
    repeat (600) @(posedge clk);
    hold_rx = 0;
  end

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    xsec_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_xsec.size() == 0) begin
        $display("%0t: unexpected result xsec=%h tuser=%b", $time, m_tdata, m_tuser);
        errors++;
      end else begin
        e = expected_xsec.pop_front();
        if (m_tdata !== e.xsec) begin
          $display("%0t: cross_section expected %h actual %h", $time, e.xsec, m_tdata);
          errors++;
        end
        if (m_tuser[0] !== e.ovf) begin
          $display("%0t: overflow expected %b actual %b", $time, e.ovf, m_tuser[0]);
          errors++;
        end
        if (m_tuser[1] !== e.inval) begin
          $display("%0t: invalid expected %b actual %b", $time, e.inval, m_tuser[1]);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- end of run
  initial begin
    wait (stim_done);
    while (expected_xsec.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0 && expected_xsec.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[sim.f]
hdl/qecs_pkg.sv
hdl/qecs_div.sv
hdl/quasielastic_cross_section.sv
tb/sv/quasielastic_cross_section_tb.sv
